/* rtl/glzw_pkg.sv */
// Shared types and constants for the GIF LZW decoder.
`default_nettype none

package glzw_pkg;

    localparam int BYTE_W    = 8;
    localparam int RES_W     = 20;
    localparam int RBITS_W   = 5;
    localparam int CWID_W    = 4;
    localparam int MCS_W     = 4;
    localparam int COUNT_W   = 7;
    localparam int LANES     = 8;
    localparam int LANE_W    = 64;
    localparam int GROUP_W   = LANES * LANE_W;
    localparam int RESULT_LIMIT = 64;
    localparam int QUEUE_DEPTH  = 4;
    localparam logic [MCS_W-1:0] RESET_MCS = 4'd8;

    // One byte handed from the intake side to the decoding side.
    typedef struct packed {
        logic              eoi;
        logic [BYTE_W-1:0] data;
    } q_entry_t;

    // Side information that travels with one pixel group.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               eoi;
        logic               bad;
    } out_flags_t;

endpackage

`default_nettype wire

/* rtl/glzw_queue.sv */
// Small FIFO between the byte intake and the decoding engine.
`default_nettype none

module glzw_queue
    import glzw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     flush,
    input  wire logic     push_valid,
    input  wire q_entry_t push_entry,
    output logic          push_ready,
    output logic          pop_valid,
    output q_entry_t      pop_entry,
    input  wire logic     pop_ready
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    q_entry_t         slots_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != (AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (flush)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_next = wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_next = rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_next = fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && !flush)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

/* rtl/glzw_front.sv */
// Byte intake: tracks sub-block lengths and forwards data bytes.
`default_nettype none

module glzw_front
    import glzw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              init,
    input  wire logic              in_valid,
    input  wire logic [BYTE_W-1:0] data_byte,
    output logic                   in_ready,
    output logic                   push_valid,
    output q_entry_t               push_entry,
    input  wire logic              push_ready
);

    logic [BYTE_W-1:0] left_reg, left_next;
    logic              done_reg, done_next;
    logic              accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        left_next       = left_reg;
        done_next       = done_reg;
        push_valid      = 1'b0;
        push_entry.eoi  = 1'b0;
        push_entry.data = data_byte;
        if (init)
        begin
            left_next = '0;
            done_next = 1'b0;
        end
        else if (accept && !done_reg)
        begin
            if (left_reg == '0)
            begin
                // A zero length byte closes the image.
                if (data_byte == '0)
                begin
                    done_next      = 1'b1;
                    push_valid     = 1'b1;
                    push_entry.eoi = 1'b1;
                end
                else
                    left_next = data_byte;
            end
            else
            begin
                left_next  = left_reg - 1'b1;
                push_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/glzw_back.sv */
// Decoding engine: code unpacking, table walk, pixel buffering and grouping.
`default_nettype none

module glzw_back
    import glzw_pkg::*;
#(
    parameter int MAX_CODE_BITS     = 12,
    parameter int PIXELS_PER_RESULT = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               init,
    input  wire logic [MCS_W-1:0]   eff_size,
    input  wire logic               q_valid,
    input  wire q_entry_t           q_entry,
    output logic                    q_ready,
    output logic                    out_valid,
    output logic [GROUP_W-1:0]      out_group,
    output out_flags_t              out_flags,
    input  wire logic               out_ready
);

    localparam int MCB       = MAX_CODE_BITS;
    localparam int TD        = 1 << MCB;
    localparam int SLOT_W    = MCB + 1;
    localparam int SP_W      = MCB + 1;
    localparam int PIX_DEPTH = RESULT_LIMIT * PIXELS_PER_RESULT;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int PN_W      = PIX_AW + 1;
    localparam int WS_W      = $clog2(RESULT_LIMIT);
    localparam logic [SLOT_W-1:0] RESET_NEXT = SLOT_W'((1 << RESET_MCS) + 2);
    localparam logic [CWID_W-1:0] RESET_WIDTH = CWID_W'(RESET_MCS + 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOAD    = 9'b000000010,
        S_CHECK   = 9'b000000100,
        S_CODE    = 9'b000001000,
        S_WALK    = 9'b000010000,
        S_TAIL    = 9'b000100000,
        S_POP     = 9'b001000000,
        S_GATHER  = 9'b010000000,
        S_PRESENT = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [RES_W-1:0]     res_reg, res_next;
    logic [RBITS_W-1:0]   bits_reg, bits_next;
    logic [CWID_W-1:0]    width_reg, width_next;
    logic [SLOT_W-1:0]    next_reg, next_next;
    logic                 ac_reg, ac_next;
    logic [MCB-1:0]       old_reg, old_next;
    logic [BYTE_W-1:0]    first_reg, first_next;
    logic                 fin_reg, fin_next;
    logic                 bad_reg, bad_next;
    logic [MCB-1:0]       cv_reg, cv_next;
    logic [MCB-1:0]       walk_reg, walk_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic                 pop_v_reg, pop_v_next;
    logic [PN_W-1:0]      pix_n_reg, pix_n_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [PN_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]   issue_reg, issue_next;
    logic                 g_v_reg, g_v_next;
    logic [WS_W-1:0]      wslot_reg, wslot_next;
    logic [GROUP_W-1:0]   asm_reg, asm_next;
    logic                 ov_reg, ov_next;
    logic [GROUP_W-1:0]   og_reg, og_next;
    out_flags_t           of_reg, of_next;

    // Memories.
    logic [MCB-1:0]       pre_mem [TD];
    logic [BYTE_W-1:0]    suf_mem [TD];
    logic [BYTE_W-1:0]    stk_mem [TD];
    logic [BYTE_W-1:0]    pix_mem [PIX_DEPTH];
    logic [MCB-1:0]       pre_q;
    logic [BYTE_W-1:0]    suf_q, stk_q, pix_q;
    logic                 tbl_we;
    logic [MCB-1:0]       tbl_ra;
    logic                 stk_we;
    logic [MCB-1:0]       stk_wa, stk_ra;
    logic [BYTE_W-1:0]    stk_wd;
    logic                 pix_we;
    logic [PIX_AW-1:0]    pix_ra;

    logic [SLOT_W-1:0]    clr, base, top, cv_ext, walk_c_ext, grown;
    logic [MCB-1:0]       walk_c;
    logic [RES_W-1:0]     mask;

    assign clr    = SLOT_W'(1) << eff_size;
    assign base   = clr + SLOT_W'(2);
    assign top    = SLOT_W'(1) << width_reg;
    assign cv_ext = {1'b0, cv_reg};
    assign mask   = (RES_W'(1) << width_reg) - RES_W'(1);
    assign pix_we = pop_v_reg && (pix_n_reg < PN_W'(PIX_DEPTH));

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_group = og_reg;
    assign out_flags = of_reg;

    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        bits_next   = bits_reg;
        width_next  = width_reg;
        next_next   = next_reg;
        ac_next     = ac_reg;
        old_next    = old_reg;
        first_next  = first_reg;
        fin_next    = fin_reg;
        bad_next    = bad_reg;
        cv_next     = cv_reg;
        walk_next   = walk_reg;
        sp_next     = sp_reg;
        pop_v_next  = 1'b0;
        pix_n_next  = pix_n_reg;
        byte_next   = byte_reg;
        rd_ptr_next = rd_ptr_reg;
        issue_next  = issue_reg;
        g_v_next    = 1'b0;
        wslot_next  = wslot_reg;
        asm_next    = asm_reg;
        ov_next     = ov_reg;
        og_next     = og_reg;
        of_next     = of_reg;
        tbl_we      = 1'b0;
        tbl_ra      = walk_reg;
        stk_we      = 1'b0;
        stk_wa      = sp_reg[MCB-1:0];
        stk_wd      = suf_q;
        stk_ra      = MCB'(sp_reg - SP_W'(1));
        pix_ra      = rd_ptr_reg[PIX_AW-1:0];
        walk_c      = cv_reg;
        walk_c_ext  = cv_ext;
        grown       = next_reg;

        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (pix_we)
            pix_n_next = pix_n_reg + 1'b1;
        if (g_v_reg)
        begin
            asm_next[{wslot_reg, 3'b000} +: BYTE_W] = pix_q;
            wslot_next = wslot_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !fin_reg)
                begin
                    pix_n_next  = '0;
                    bad_next    = 1'b0;
                    rd_ptr_next = '0;
                    issue_next  = '0;
                    wslot_next  = '0;
                    asm_next    = '0;
                    if (q_entry.eoi)
                    begin
                        fin_next   = 1'b1;
                        state_next = S_GATHER;
                    end
                    else
                    begin
                        byte_next  = q_entry.data;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                res_next   = res_reg | (RES_W'(byte_reg) << bits_reg);
                bits_next  = bits_reg + RBITS_W'(8);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!fin_reg && (bits_reg >= {1'b0, width_reg}))
                begin
                    cv_next    = MCB'(res_reg & mask);
                    res_next   = res_reg >> width_reg;
                    bits_next  = bits_reg - {1'b0, width_reg};
                    state_next = S_CODE;
                end
                else if (pix_n_reg == '0 && !fin_reg && !bad_reg)
                    state_next = S_IDLE;
                else
                    state_next = S_GATHER;
            end
            S_CODE:
            begin
                sp_next = '0;
                if (cv_ext == clr + SLOT_W'(1))
                begin
                    fin_next   = 1'b1;
                    state_next = S_CHECK;
                end
                else if (cv_ext == clr)
                begin
                    ac_next    = 1'b1;
                    width_next = eff_size + CWID_W'(1);
                    next_next  = base;
                    state_next = S_CHECK;
                end
                else if (ac_reg)
                begin
                    // First code after a clear: out of range reads as zero.
                    ac_next = 1'b0;
                    walk_c  = (cv_ext >= next_reg) ? '0 : cv_reg;
                    old_next   = walk_c;
                    first_next = walk_c[BYTE_W-1:0];
                    stk_we     = 1'b1;
                    stk_wa     = '0;
                    stk_wd     = walk_c[BYTE_W-1:0];
                    sp_next    = SP_W'(1);
                    state_next = S_POP;
                end
                else
                begin
                    if (cv_ext > next_reg)
                    begin
                        bad_next = 1'b1;
                        cv_next  = '0;
                        walk_c   = '0;
                    end
                    else if (cv_ext == next_reg)
                    begin
                        // String not yet in the table: old string plus its first pixel.
                        walk_c  = old_reg;
                        stk_we  = 1'b1;
                        stk_wa  = '0;
                        stk_wd  = first_reg;
                        sp_next = SP_W'(1);
                    end
                    walk_c_ext = {1'b0, walk_c};
                    walk_next  = walk_c;
                    tbl_ra     = walk_c;
                    state_next = (walk_c_ext >= base) ? S_WALK : S_TAIL;
                end
            end
            S_WALK:
            begin
                stk_we     = 1'b1;
                stk_wa     = sp_reg[MCB-1:0];
                stk_wd     = suf_q;
                sp_next    = sp_reg + SP_W'(1);
                walk_next  = pre_q;
                tbl_ra     = pre_q;
                if (!(({1'b0, pre_q} >= base) && (sp_next < SP_W'(TD - 1))))
                    state_next = S_TAIL;
            end
            S_TAIL:
            begin
                stk_we  = 1'b1;
                stk_wa  = sp_reg[MCB-1:0];
                stk_wd  = walk_reg[BYTE_W-1:0];
                sp_next = sp_reg + SP_W'(1);
                if (next_reg < top)
                begin
                    tbl_we     = 1'b1;
                    grown      = next_reg + SLOT_W'(1);
                    old_next   = cv_reg;
                    first_next = walk_reg[BYTE_W-1:0];
                end
                next_next = grown;
                if (grown >= top && width_reg < CWID_W'(MCB))
                    width_next = width_reg + CWID_W'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sp_reg != '0)
                begin
                    stk_ra     = MCB'(sp_reg - SP_W'(1));
                    sp_next    = sp_reg - SP_W'(1);
                    pop_v_next = 1'b1;
                end
                else
                    state_next = S_CHECK;
            end
            S_GATHER:
            begin
                if (issue_reg < COUNT_W'(PIXELS_PER_RESULT) && rd_ptr_reg < pix_n_reg)
                begin
                    pix_ra      = rd_ptr_reg[PIX_AW-1:0];
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    issue_next  = issue_reg + 1'b1;
                    g_v_next    = 1'b1;
                end
                else
                    state_next = S_PRESENT;
            end
            S_PRESENT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next       = 1'b1;
                    og_next       = asm_reg;
                    of_next.count = issue_reg;
                    of_next.last  = (rd_ptr_reg == pix_n_reg);
                    of_next.eoi   = fin_reg;
                    of_next.bad   = bad_reg;
                    asm_next      = '0;
                    issue_next    = '0;
                    wslot_next    = '0;
                    state_next    = (rd_ptr_reg == pix_n_reg) ? S_IDLE : S_GATHER;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= '0;
            bits_reg  <= '0;
            width_reg <= RESET_WIDTH;
            next_reg  <= RESET_NEXT;
            ac_reg    <= 1'b1;
            old_reg   <= '0;
            first_reg <= '0;
            fin_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            sp_reg    <= '0;
            pop_v_reg <= 1'b0;
            pix_n_reg <= '0;
            rd_ptr_reg <= '0;
            issue_reg <= '0;
            g_v_reg   <= 1'b0;
            wslot_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else if (init)
        begin
            state_reg <= S_IDLE;
            res_reg   <= '0;
            bits_reg  <= '0;
            width_reg <= eff_size + CWID_W'(1);
            next_reg  <= base;
            ac_reg    <= 1'b1;
            old_reg   <= '0;
            first_reg <= '0;
            fin_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            sp_reg    <= '0;
            pop_v_reg <= 1'b0;
            pix_n_reg <= '0;
            rd_ptr_reg <= '0;
            issue_reg <= '0;
            g_v_reg   <= 1'b0;
            wslot_reg <= '0;
            ov_reg    <= ov_next;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            bits_reg  <= bits_next;
            width_reg <= width_next;
            next_reg  <= next_next;
            ac_reg    <= ac_next;
            old_reg   <= old_next;
            first_reg <= first_next;
            fin_reg   <= fin_next;
            bad_reg   <= bad_next;
            sp_reg    <= sp_next;
            pop_v_reg <= pop_v_next;
            pix_n_reg <= pix_n_next;
            rd_ptr_reg <= rd_ptr_next;
            issue_reg <= issue_next;
            g_v_reg   <= g_v_next;
            wslot_reg <= wslot_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cv_reg   <= cv_next;
        walk_reg <= walk_next;
        byte_reg <= byte_next;
        asm_reg  <= asm_next;
        og_reg   <= og_next;
        of_reg   <= of_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            pre_mem[next_reg[MCB-1:0]] <= old_reg;
            suf_mem[next_reg[MCB-1:0]] <= walk_reg[BYTE_W-1:0];
        end
        pre_q <= pre_mem[tbl_ra];
        suf_q <= suf_mem[tbl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        stk_q <= stk_mem[stk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_n_reg[PIX_AW-1:0]] <= stk_q;
        pix_q <= pix_mem[pix_ra];
    end

endmodule

`default_nettype wire

/* rtl/gif_lzw_decoder.sv */
// GIF LZW decoder: one image-data byte per request in, pixel groups out.
// Flow: a data byte passes through the queue, then the engine loads it into its bit reservoir,
// decodes each code it completes (clear and end codes included), walks the prefix table onto
// the reverse stack, moves the pixels off the stack into a buffer and packs them into groups.
// The engine takes the next byte from the queue only once it is through with the last one;
// length bytes are absorbed at one per cycle while the queue has room. Reset (rst_n,
// asynchronous) sets min_code_size to 8; memories keep contents.
`default_nettype none

module gif_lzw_decoder
    import glzw_pkg::*;
#(
    parameter int MAX_CODE_BITS     = 12,
    parameter int PIXELS_PER_RESULT = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [MCS_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BYTE_W-1:0]  data_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [LANE_W-1:0]       pixels_a,
    output logic [LANE_W-1:0]       pixels_b,
    output logic [LANE_W-1:0]       pixels_c,
    output logic [LANE_W-1:0]       pixels_d,
    output logic [LANE_W-1:0]       pixels_e,
    output logic [LANE_W-1:0]       pixels_f,
    output logic [LANE_W-1:0]       pixels_g,
    output logic [LANE_W-1:0]       pixels_h,
    output logic [COUNT_W-1:0]      pixel_count,
    output logic                    last_of_run,
    output logic                    end_of_image,
    output logic                    bad_code
);

    // The programmed code size is held as written; the decoder uses it clamped to
    // one through MAX_CODE_BITS-1.
    logic [MCS_W-1:0]  mcs_reg;
    logic [MCS_W-1:0]  mcs_src;
    logic [MCS_W-1:0]  eff_size;
    logic              push_valid, push_ready;
    q_entry_t          push_entry;
    logic              q_valid, q_ready;
    q_entry_t          q_entry;
    logic [GROUP_W-1:0] group;
    out_flags_t        flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mcs_reg <= RESET_MCS;
        else if (cfg_we)
            mcs_reg <= cfg_data;
    end

    // A write takes effect in the same cycle, so the reinitialized state already
    // reflects the new code size.
    assign mcs_src = cfg_we ? cfg_data : mcs_reg;

    always_comb
    begin
        if (mcs_src == '0)
            eff_size = MCS_W'(1);
        else if (mcs_src > MCS_W'(MAX_CODE_BITS - 1))
            eff_size = MCS_W'(MAX_CODE_BITS - 1);
        else
            eff_size = mcs_src;
    end

    // The intake strips sub-block lengths and spots the zero-length terminator.
    glzw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (cfg_we),
        .in_valid   (in_valid),
        .data_byte  (data_byte),
        .in_ready   (in_ready),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // The queue lets the intake keep taking requests while the engine is busy.
    glzw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .flush      (cfg_we),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry),
        .pop_ready  (q_ready)
    );

    // The engine unpacks codes, walks the string table, and packs pixels into
    // groups held in its output register until taken.
    glzw_back #(
        .MAX_CODE_BITS     (MAX_CODE_BITS),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (cfg_we),
        .eff_size  (eff_size),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_ready   (q_ready),
        .out_valid (out_valid),
        .out_group (group),
        .out_flags (flags),
        .out_ready (out_ready)
    );

    assign pixels_a     = group[0*LANE_W +: LANE_W];
    assign pixels_b     = group[1*LANE_W +: LANE_W];
    assign pixels_c     = group[2*LANE_W +: LANE_W];
    assign pixels_d     = group[3*LANE_W +: LANE_W];
    assign pixels_e     = group[4*LANE_W +: LANE_W];
    assign pixels_f     = group[5*LANE_W +: LANE_W];
    assign pixels_g     = group[6*LANE_W +: LANE_W];
    assign pixels_h     = group[7*LANE_W +: LANE_W];
    assign pixel_count  = flags.count;
    assign last_of_run  = flags.last;
    assign end_of_image = flags.eoi;
    assign bad_code     = flags.bad;

endmodule

`default_nettype wire
